FILE: hdl/tmcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared constants, codes and command types of the text mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int SHIFT_LAST = CELL_COUNT - COLUMNS;

    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int WORD_W  = 16;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int ATTR_W  = 8;

    localparam int TAB_STOP = 4;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ATTR_SEL = 1'b0;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              scroll;
        t_addr             addr;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_cmd;

endpackage

FILE: hdl/tmcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_front
// Accepts input beats, tracks the cursor and turns each beat into a command.
// ----------------------------------------------------------------------------
module tmcw_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_take,
    input  logic [tmcw_pkg::KIND_W-1:0]    i_kind,
    input  logic [tmcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tmcw_pkg::INDEX_W-1:0]   i_cell_index,
    output logic                           o_push,
    output tmcw_pkg::t_cmd                 o_cmd
);

    logic [tmcw_pkg::ROW_W-1:0] r_row, n_row;
    logic [tmcw_pkg::COL_W-1:0] r_col, n_col;
    logic [tmcw_pkg::COL_W:0]   col_x, col_w;
    logic [tmcw_pkg::ROW_W:0]   row_x;
    logic [tmcw_pkg::COL_W-1:0] wcol;
    logic                       scroll;

    assign o_push = i_valid && i_take;

    always_comb begin
        col_x  = {1'b0, r_col};
        row_x  = {1'b0, r_row};
        wcol   = r_col;
        scroll = 1'b0;
        o_cmd.op   = tmcw_pkg::OP_NONE;
        o_cmd.ch   = i_char_code;
        o_cmd.addr = tmcw_pkg::t_addr'(i_cell_index);
        case (i_kind)
            tmcw_pkg::KIND_PUT: begin
                case (i_char_code)
                    tmcw_pkg::CH_NUL: begin
                    end
                    tmcw_pkg::CH_LF: begin
                        col_x = '0;
                        row_x = row_x + 1'b1;
                    end
                    tmcw_pkg::CH_TAB: begin
                        col_x = (col_x | (tmcw_pkg::COL_W+1)'(tmcw_pkg::TAB_STOP - 1)) + 1'b1;
                    end
                    tmcw_pkg::CH_CR: begin
                        col_x = '0;
                    end
                    tmcw_pkg::CH_BS: begin
                        if (r_col != '0) begin
                            col_x = col_x - 1'b1;
                        end
                        wcol     = col_x[tmcw_pkg::COL_W-1:0];
                        o_cmd.op = tmcw_pkg::OP_WRITE;
                        o_cmd.ch = tmcw_pkg::BLANK_CHAR;
                    end
                    default: begin
                        o_cmd.op = tmcw_pkg::OP_WRITE;
                        col_x    = col_x + 1'b1;
                    end
                endcase
                o_cmd.addr = tmcw_pkg::t_addr'(r_row) * tmcw_pkg::t_addr'(tmcw_pkg::COLUMNS)
                           + tmcw_pkg::t_addr'(wcol);
                if (col_x >= (tmcw_pkg::COL_W+1)'(tmcw_pkg::COLUMNS)) begin
                    col_x = '0;
                    row_x = row_x + 1'b1;
                end
                if (row_x >= (tmcw_pkg::ROW_W+1)'(tmcw_pkg::ROWS)) begin
                    row_x  = (tmcw_pkg::ROW_W+1)'(tmcw_pkg::ROWS - 1);
                    scroll = 1'b1;
                end
            end
            tmcw_pkg::KIND_READ: begin
                if (32'(i_cell_index) < tmcw_pkg::CELL_COUNT) begin
                    o_cmd.op = tmcw_pkg::OP_READ;
                end
            end
            tmcw_pkg::KIND_CLEAR: begin
                o_cmd.op = tmcw_pkg::OP_CLEAR;
                col_x    = '0;
                row_x    = '0;
            end
            default: begin
            end
        endcase
        col_w        = col_x;
        n_col        = col_w[tmcw_pkg::COL_W-1:0];
        n_row        = row_x[tmcw_pkg::ROW_W-1:0];
        o_cmd.scroll = scroll;
        o_cmd.row    = n_row;
        o_cmd.col    = n_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (o_push) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

FILE: hdl/tmcw_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tmcw_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tmcw_pkg::t_cmd i_push_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output tmcw_pkg::t_cmd o_pop_cmd,
    output logic           o_empty
);

    tmcw_pkg::t_cmd               r_slot [tmcw_pkg::QUEUE_DEPTH];
    logic [tmcw_pkg::QPTR_W-1:0]  r_wr, r_rd;
    logic [tmcw_pkg::QPTR_W:0]    r_count;

    assign o_full    = (r_count == (tmcw_pkg::QPTR_W+1)'(tmcw_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_cmd = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (32'(r_wr) == tmcw_pkg::QUEUE_DEPTH - 1) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (32'(r_rd) == tmcw_pkg::QUEUE_DEPTH - 1) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/tmcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_back
// Holds the cell store and carries out commands: writes, reads, scrolls and
// clears, then presents one result beat per command.
// ----------------------------------------------------------------------------
module tmcw_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tmcw_pkg::ATTR_W-1:0]    i_attr,
    input  logic                           i_empty,
    input  tmcw_pkg::t_cmd                 i_cmd,
    output logic                           o_pop,
    output logic                           o_init_busy,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [tmcw_pkg::WORD_W-1:0]    o_cell_word,
    output logic [tmcw_pkg::ROW_W-1:0]     o_cursor_row,
    output logic [tmcw_pkg::COL_W-1:0]     o_cursor_column,
    output logic                           o_scrolled
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_READ   = 7'b0000100,
        S_SHIFT  = 7'b0001000,
        S_BLANK  = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state                         r_state, n_state;
    tmcw_pkg::t_addr                r_cnt, n_cnt;
    tmcw_pkg::t_cmd                 r_cmd, n_cmd;
    logic [tmcw_pkg::WORD_W-1:0]    r_word, n_word;
    logic [tmcw_pkg::WORD_W-1:0]    r_mem [tmcw_pkg::CELL_COUNT];
    logic [tmcw_pkg::WORD_W-1:0]    r_rdata;
    logic                           we;
    tmcw_pkg::t_addr                wa, ra;
    logic [tmcw_pkg::WORD_W-1:0]    wd;
    logic                           load_out;
    logic                           r_valid;

    assign o_init_busy = (r_state == S_INIT);
    assign o_valid     = r_valid;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_cmd    = r_cmd;
        n_word   = r_word;
        we       = 1'b0;
        wa       = r_cnt;
        wd       = {i_attr, tmcw_pkg::BLANK_CHAR};
        ra       = r_cnt;
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_INIT: begin
                we = 1'b1;
                wd = {tmcw_pkg::RESET_ATTR, tmcw_pkg::BLANK_CHAR};
                if (32'(r_cnt) == tmcw_pkg::CELL_COUNT - 1) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_cmd;
                    n_word = '0;
                    n_cnt  = '0;
                    n_state = i_cmd.scroll ? S_SHIFT : S_RESULT;
                    case (i_cmd.op)
                        tmcw_pkg::OP_WRITE: begin
                            we = 1'b1;
                            wa = i_cmd.addr;
                            wd = {i_attr, i_cmd.ch};
                        end
                        tmcw_pkg::OP_READ: begin
                            ra      = i_cmd.addr;
                            n_state = S_READ;
                        end
                        tmcw_pkg::OP_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_word  = r_rdata;
                n_state = S_RESULT;
            end
            S_SHIFT: begin
                if (32'(r_cnt) < tmcw_pkg::SHIFT_LAST) begin
                    ra = r_cnt + tmcw_pkg::t_addr'(tmcw_pkg::COLUMNS);
                end
                if (r_cnt != '0) begin
                    we = 1'b1;
                    wa = r_cnt - 1'b1;
                    wd = r_rdata;
                end
                if (32'(r_cnt) == tmcw_pkg::SHIFT_LAST) begin
                    n_state = S_BLANK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_BLANK, S_CLEAR: begin
                we = 1'b1;
                if (32'(r_cnt) == tmcw_pkg::CELL_COUNT - 1) begin
                    n_cnt   = '0;
                    n_state = S_RESULT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RESULT: begin
                if (!r_valid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rdata <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_word <= n_word;
        if (load_out) begin
            o_cell_word     <= r_word;
            o_cursor_row    <= r_cmd.row;
            o_cursor_column <= r_cmd.col;
            o_scrolled      <= r_cmd.scroll;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (load_out) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/text_mode_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console_writer
// Text cell store with a cursor, fed with characters and read cell by cell.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Beat contents
//  input     i_valid / o_stall      i_kind, i_char_code, i_cell_index
//  result    o_valid / i_stall      o_cell_word, o_cursor_row, o_cursor_column,
//                                   o_scrolled
//  config    psel/penable/pready    paddr, pwdata, prdata (text attribute)
//
// An ordinary character or an idle command passes S_IDLE and S_RESULT in the back
// sequencer, a cell read also S_READ; these steps follow from the registered read
// of the cell store and the result register.
// A scroll or a clear walks the whole store.
// After reset a clearing pass fills the store with blanks and holds o_stall
// high. A two-beat command queue lets input beats be taken while the back end
// works or while a result waits under i_stall.
// ----------------------------------------------------------------------------
module text_mode_console_writer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [tmcw_pkg::KIND_W-1:0]     i_kind,
    input  logic [tmcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tmcw_pkg::INDEX_W-1:0]    i_cell_index,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [tmcw_pkg::WORD_W-1:0]     o_cell_word,
    output logic [tmcw_pkg::ROW_W-1:0]      o_cursor_row,
    output logic [tmcw_pkg::COL_W-1:0]      o_cursor_column,
    output logic                            o_scrolled,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tmcw_pkg::PADDR_W-1:0]    paddr,
    input  logic [tmcw_pkg::PDATA_W-1:0]    pwdata,
    output logic [tmcw_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    logic [tmcw_pkg::ATTR_W-1:0] r_attr;
    logic                        push, full, empty, pop, init_busy;
    tmcw_pkg::t_cmd              push_cmd, pop_cmd;

    assign pready  = 1'b1;
    assign o_stall = full || init_busy;
    assign prdata  = (paddr[2] == tmcw_pkg::REG_ATTR_SEL)
                   ? tmcw_pkg::PDATA_W'(r_attr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tmcw_pkg::RESET_ATTR;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == tmcw_pkg::REG_ATTR_SEL) begin
            r_attr <= pwdata[tmcw_pkg::ATTR_W-1:0];
        end
    end

    tmcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_take       (!o_stall),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    tmcw_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (full),
        .i_pop      (pop),
        .o_pop_cmd  (pop_cmd),
        .o_empty    (empty)
    );

    tmcw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_attr          (r_attr),
        .i_empty         (empty),
        .i_cmd           (pop_cmd),
        .o_pop           (pop),
        .o_init_busy     (init_busy),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cell_word     (o_cell_word),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_column (o_cursor_column),
        .o_scrolled      (o_scrolled)
    );

endmodule
